// ===== design/nwrl_pkg.sv =====
`default_nettype none

package nwrl_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned RANK_W    = 3;
  localparam int unsigned S_TDATA_W = 104;
  localparam int unsigned M_TDATA_W = 48;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_TRANSLATED = 3'd0,
    ST_NO_MATCH   = 3'd1,
    ST_STORED     = 3'd2,
    ST_DUPLICATE  = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  // Match rank: exact/exact, exact/any, any/exact, any/any; NONE is worse than all
  localparam logic [RANK_W-1:0] RANK_NONE = 3'd4;

  // Word travelling down the cell row
  typedef struct packed {
    logic                valid;
    op_e                 op;
    logic [ADDR_W-1:0]   addr;
    logic                addr_any;
    logic [PORT_W-1:0]   port;
    logic                port_any;
    logic [ADDR_W-1:0]   new_addr;
    logic [PORT_W-1:0]   new_port;
    logic                dup;
    logic                stored;
    logic [RANK_W-1:0]   rank;
    logic [ADDR_W-1:0]   hit_addr;
    logic [PORT_W-1:0]   hit_port;
  } tok_t;

endpackage

`default_nettype wire

// ===== design/nwrl_cell.sv =====
`default_nettype none

module nwrl_cell (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              en_i,
  input  nwrl_pkg::tok_t   tok_i,
  output nwrl_pkg::tok_t   tok_o
);

  logic                          used_q;
  logic [nwrl_pkg::ADDR_W-1:0]   rule_addr_q;
  logic                          rule_addr_any_q;
  logic [nwrl_pkg::PORT_W-1:0]   rule_port_q;
  logic                          rule_port_any_q;
  logic [nwrl_pkg::ADDR_W-1:0]   tgt_addr_q;
  logic [nwrl_pkg::PORT_W-1:0]   tgt_port_q;
  nwrl_pkg::tok_t                tok_q;
  nwrl_pkg::tok_t                tok_d;

  logic                          key_hit;
  logic                          addr_ok;
  logic                          port_ok;
  logic                          look_hit;
  logic [nwrl_pkg::RANK_W-1:0]   rank;
  logic                          store;

  always_comb begin
    key_hit  = used_q
               && (rule_addr_q == tok_i.addr) && (rule_addr_any_q == tok_i.addr_any)
               && (rule_port_q == tok_i.port) && (rule_port_any_q == tok_i.port_any);
    addr_ok  = rule_addr_any_q || (rule_addr_q == tok_i.addr);
    port_ok  = rule_port_any_q || (rule_port_q == tok_i.port);
    look_hit = used_q && addr_ok && port_ok;
    rank     = {1'b0, rule_addr_any_q, rule_port_any_q};
    // Cells fill in order, so the first free cell has seen every stored key
    store    = tok_i.valid && (tok_i.op == nwrl_pkg::OP_INSERT)
               && !used_q && !tok_i.dup && !tok_i.stored;

    tok_d = tok_i;
    if (tok_i.valid) begin
      unique case (tok_i.op)
        nwrl_pkg::OP_INSERT: begin
          if (key_hit) begin
            tok_d.dup = 1'b1;
          end
          if (store) begin
            tok_d.stored = 1'b1;
          end
        end
        nwrl_pkg::OP_LOOKUP: begin
          // keep the best rank seen so far
          if (look_hit && (rank < tok_i.rank)) begin
            tok_d.rank     = rank;
            tok_d.hit_addr = tgt_addr_q;
            tok_d.hit_port = tgt_port_q;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else if (en_i) begin
      tok_q <= tok_d;
      if (store) begin
        used_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && store) begin
      rule_addr_q     <= tok_i.addr;
      rule_addr_any_q <= tok_i.addr_any;
      rule_port_q     <= tok_i.port;
      rule_port_any_q <= tok_i.port_any;
      tgt_addr_q      <= tok_i.new_addr;
      tgt_port_q      <= tok_i.new_port;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== design/nat_wildcard_rule_lookup.sv =====
// Each accepted word walks the whole row of rule cells, one cell per cycle,
// before the next word is taken.
// The output register lets a new word enter while the last result waits.
// Reset (rst_ni low, asynchronous) empties every rule cell and the channels.
`default_nettype none

module nat_wildcard_rule_lookup #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // key_addr[31:0], key_addr_any[32], key_port[48:33], key_port_any[49],
  // new_addr[81:50], new_port[97:82], zero fill [103:98]
  input  wire  [nwrl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // opcode[0]
  input  wire  [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // out_addr[31:0], out_port[47:32]
  output logic [nwrl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // status[2:0]
  output logic [nwrl_pkg::STATUS_W-1:0]      m_axis_tuser
);

  nwrl_pkg::tok_t                      tok_w [TABLE_ENTRIES+1];
  nwrl_pkg::tok_t                      entry_q;
  nwrl_pkg::tok_t                      entry_new;
  nwrl_pkg::tok_t                      last;
  logic                                busy_q;
  logic                                accept;
  logic                                out_free;
  logic                                adv;
  logic                                load_out;
  logic                                m_valid_q;
  logic [nwrl_pkg::M_TDATA_W-1:0]      m_data_q;
  logic [nwrl_pkg::M_TDATA_W-1:0]      m_data_d;
  logic [nwrl_pkg::STATUS_W-1:0]       m_user_q;
  logic [nwrl_pkg::STATUS_W-1:0]       m_user_d;
  logic                                in_addr_any;
  logic                                in_port_any;
  logic                                is_insert;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && !busy_q;

  assign last     = tok_w[TABLE_ENTRIES];
  assign out_free = !m_valid_q || m_axis_tready;
  // hold the row while a finished word cannot leave
  assign adv      = !last.valid || out_free;
  assign load_out = last.valid && out_free;

  always_comb begin
    is_insert   = (nwrl_pkg::op_e'(s_axis_tuser[0]) == nwrl_pkg::OP_INSERT);
    in_addr_any = is_insert && s_axis_tdata[32];
    in_port_any = is_insert && s_axis_tdata[49];

    entry_new          = '0;
    entry_new.valid    = 1'b1;
    entry_new.op       = nwrl_pkg::op_e'(s_axis_tuser[0]);
    // a wildcard key stores a zero value
    entry_new.addr     = in_addr_any ? '0 : s_axis_tdata[31:0];
    entry_new.addr_any = in_addr_any;
    entry_new.port     = in_port_any ? '0 : s_axis_tdata[48:33];
    entry_new.port_any = in_port_any;
    entry_new.new_addr = s_axis_tdata[81:50];
    entry_new.new_port = s_axis_tdata[97:82];
    entry_new.rank     = nwrl_pkg::RANK_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (accept) begin
      entry_q <= entry_new;
    end else if (adv) begin
      entry_q.valid <= 1'b0;
    end
  end

  assign tok_w[0] = entry_q;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    nwrl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .tok_i  (tok_w[g]),
      .tok_o  (tok_w[g+1])
    );
  end

  always_comb begin
    m_data_d = '0;
    m_user_d = nwrl_pkg::ST_NO_MATCH;
    unique case (last.op)
      nwrl_pkg::OP_INSERT: begin
        if (last.dup) begin
          m_user_d = nwrl_pkg::ST_DUPLICATE;
        end else if (last.stored) begin
          m_user_d = nwrl_pkg::ST_STORED;
        end else begin
          m_user_d = nwrl_pkg::ST_FULL;
        end
      end
      nwrl_pkg::OP_LOOKUP: begin
        if (last.rank != nwrl_pkg::RANK_NONE) begin
          m_user_d = nwrl_pkg::ST_TRANSLATED;
          m_data_d = {last.hit_port, last.hit_addr};
        end
      end
      default: begin
        m_user_d = nwrl_pkg::ST_NO_MATCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load_out) begin
        busy_q <= 1'b0;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

// ===== design/nwrl_checker.sv =====
`default_nettype none

module nwrl_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [nwrl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input wire [nwrl_pkg::STATUS_W-1:0]      m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == nwrl_pkg::ST_TRANSLATED) || (m_axis_tuser == nwrl_pkg::ST_NO_MATCH) ||
      (m_axis_tuser == nwrl_pkg::ST_STORED) || (m_axis_tuser == nwrl_pkg::ST_DUPLICATE) ||
      (m_axis_tuser == nwrl_pkg::ST_FULL))
    else $error("illegal status code");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != nwrl_pkg::ST_TRANSLATED) |-> (m_axis_tdata == '0))
    else $error("non-zero payload without translation");

  // one word in flight: input closes after each accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after accept");

endmodule

bind nat_wildcard_rule_lookup nwrl_checker u_nwrl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TABLE_ENTRIES = 64;

  typedef struct packed {
    nwrl_pkg::op_e                op;
    logic [nwrl_pkg::ADDR_W-1:0]  addr;
    logic                         addr_any;
    logic [nwrl_pkg::PORT_W-1:0]  port;
    logic                         port_any;
    logic [nwrl_pkg::ADDR_W-1:0]  new_addr;
    logic [nwrl_pkg::PORT_W-1:0]  new_port;
  } rule_req_t;

  typedef struct packed {
    nwrl_pkg::status_e            status;
    logic [nwrl_pkg::ADDR_W-1:0]  addr;
    logic [nwrl_pkg::PORT_W-1:0]  port;
  } xlat_t;

  // Shadow copy of the rule table; predicts one reply per accepted word
  class nat_rule_shadow;
    logic [49:0]   keys [TABLE_ENTRIES];
    logic [47:0]   targets [TABLE_ENTRIES];
    int unsigned   used;
    xlat_t         pending_q [$];
    int unsigned   errors;
    int unsigned   n_words;
    int unsigned   n_status [5];
    int unsigned   n_rank [4];

    function new();
      used = 0;
      errors = 0;
      n_words = 0;
      foreach (n_status[i]) n_status[i] = 0;
      foreach (n_rank[i]) n_rank[i] = 0;
    endfunction

    // Wildcarded values are stored as zero, so they never tell keys apart
    static function logic [49:0] rule_key(logic [nwrl_pkg::ADDR_W-1:0] a, logic aa,
                                          logic [nwrl_pkg::PORT_W-1:0] p, logic pa);
      return {pa, aa, (pa ? 16'h0000 : p), (aa ? 32'h0000_0000 : a)};
    endfunction

    function void note_request(rule_req_t r);
      xlat_t        x;
      logic [49:0]  k;
      logic [49:0]  cand [4];
      bit           done;
      x.status = nwrl_pkg::ST_NO_MATCH;
      x.addr = '0;
      x.port = '0;
      done = 1'b0;
      if (r.op == nwrl_pkg::OP_INSERT) begin
        k = rule_key(r.addr, r.addr_any, r.port, r.port_any);
        for (int i = 0; i < used; i++) begin
          if (!done && keys[i] == k) begin
            x.status = nwrl_pkg::ST_DUPLICATE;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (used >= TABLE_ENTRIES) begin
            x.status = nwrl_pkg::ST_FULL;
          end else begin
            keys[used] = k;
            targets[used] = {r.new_port, r.new_addr};
            used++;
            x.status = nwrl_pkg::ST_STORED;
          end
        end
      end else begin
        cand[0] = rule_key(r.addr, 1'b0, r.port, 1'b0);
        cand[1] = rule_key(r.addr, 1'b0, '0, 1'b1);
        cand[2] = rule_key('0, 1'b1, r.port, 1'b0);
        cand[3] = rule_key('0, 1'b1, '0, 1'b1);
        for (int rk = 0; rk < 4; rk++) begin
          for (int i = 0; i < used; i++) begin
            if (!done && keys[i] == cand[rk]) begin
              x.status = nwrl_pkg::ST_TRANSLATED;
              x.addr = targets[i][31:0];
              x.port = targets[i][47:32];
              n_rank[rk]++;
              done = 1'b1;
            end
          end
        end
      end
      n_words++;
      n_status[x.status]++;
      pending_q.push_back(x);
    endfunction

    function void check_reply(logic [nwrl_pkg::STATUS_W-1:0] status,
                              logic [nwrl_pkg::ADDR_W-1:0] addr,
                              logic [nwrl_pkg::PORT_W-1:0] port);
      xlat_t x;
      if (pending_q.size() == 0) begin
        $display("%0t: reply with nothing pending: status %0d addr %h port %h",
                 $time, status, addr, port);
        errors++;
        return;
      end
      x = pending_q.pop_front();
      if (status !== x.status) begin
        $display("%0t: status expected %0d actual %0d", $time, x.status, status);
        errors++;
      end
      if (addr !== x.addr) begin
        $display("%0t: out_addr expected %h actual %h", $time, x.addr, addr);
        errors++;
      end
      if (port !== x.port) begin
        $display("%0t: out_port expected %h actual %h", $time, x.port, port);
        errors++;
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [nwrl_pkg::S_TDATA_W-1:0]   s_axis_tdata;
  logic [0:0]                       s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [nwrl_pkg::M_TDATA_W-1:0]   m_axis_tdata;
  logic [nwrl_pkg::STATUS_W-1:0]    m_axis_tuser;

  nat_rule_shadow                   sb;
  bit                               steady;
  logic [nwrl_pkg::ADDR_W-1:0]      addr_pool [8];
  logic [nwrl_pkg::PORT_W-1:0]      port_pool [8];

  nat_wildcard_rule_lookup #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Small pools make keys collide and lookups hit every rank
  function automatic logic [nwrl_pkg::ADDR_W-1:0] pick_addr();
    if ($urandom_range(9) == 0) return $urandom;
    return addr_pool[$urandom_range(7)];
  endfunction

  function automatic logic [nwrl_pkg::PORT_W-1:0] pick_port();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return port_pool[$urandom_range(7)];
  endfunction

  task automatic sender_gap();
    if (!steady && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 90)) @(posedge clk_i);
      else repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(nwrl_pkg::op_e op, logic [nwrl_pkg::ADDR_W-1:0] a, logic aa,
                           logic [nwrl_pkg::PORT_W-1:0] p, logic pa,
                           logic [nwrl_pkg::ADDR_W-1:0] na,
                           logic [nwrl_pkg::PORT_W-1:0] np);
    rule_req_t r;
    r.op = op;
    r.addr = a;
    r.addr_any = aa;
    r.port = p;
    r.port_any = pa;
    r.new_addr = na;
    r.new_port = np;
    s_axis_tdata <= {6'b000000, np, na, pa, p, aa, a};
    s_axis_tuser <= op;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(r);
    sender_gap();
  endtask

  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      send_item(nwrl_pkg::op_e'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                16'($urandom), 1'($urandom_range(1)), $urandom, 16'($urandom));
    end else if (pick < 23) begin
      send_item(nwrl_pkg::OP_INSERT, pick_addr(), ($urandom_range(3) == 0), pick_port(),
                ($urandom_range(3) == 0), $urandom, 16'($urandom));
    end else begin
      send_item(nwrl_pkg::OP_LOOKUP, pick_addr(), 1'($urandom_range(1)), pick_port(),
                1'($urandom_range(1)), $urandom, 16'($urandom));
    end
  endtask

  // Hold the input off until every pending reply is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    sb = new();
    steady = 1'b0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) begin
      addr_pool[i] = $urandom;
      port_pool[i] = 16'($urandom);
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table misses, then build up one rule per rank
    send_item(nwrl_pkg::OP_LOOKUP, 32'h0, 1'b0, 16'h0, 1'b0, 32'h0, 16'h0);
    send_item(nwrl_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF,
              16'hFFFF);
    send_item(nwrl_pkg::OP_LOOKUP, $urandom, 1'b0, 16'($urandom), 1'b0, 32'h0, 16'h0);
    // wildcarded values differ but the key is the same
    send_item(nwrl_pkg::OP_INSERT, 32'h1234_5678, 1'b1, 16'h0001, 1'b1, 32'h0, 16'h0);
    send_item(nwrl_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0, 32'hA5A5_A5A5,
              16'h5A5A);
    send_item(nwrl_pkg::OP_LOOKUP, 32'h0101_0101, 1'b0, 16'hFFFF, 1'b0, 32'h0, 16'h0);
    send_item(nwrl_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 1'b1, 32'h5A5A_5A5A,
              16'hA5A5);
    send_item(nwrl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 1'b0, 32'h0, 16'h0);
    send_item(nwrl_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 1'b0, 32'h0, 16'h0);
    send_item(nwrl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 1'b0, 32'hFFFF_FFFF,
              16'hFFFF);
    send_item(nwrl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0, 32'h0, 16'h0);
    send_item(nwrl_pkg::OP_LOOKUP, 32'h0000_0000, 1'b0, 16'hFFFF, 1'b0, 32'h0, 16'h0);
    send_item(nwrl_pkg::OP_LOOKUP, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 32'h0, 16'h0);
    send_item(nwrl_pkg::OP_INSERT, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 32'h0F0F_0F0F,
              16'hF0F0);
    send_item(nwrl_pkg::OP_LOOKUP, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 32'h0, 16'h0);
    send_item(nwrl_pkg::OP_INSERT, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 32'hFFFF_FFFF,
              16'hFFFF);
    // wildcard flags and target fields are don't-cares on lookup
    send_item(nwrl_pkg::OP_LOOKUP, 32'h0000_0000, 1'b1, 16'h0000, 1'b1, 32'hFFFF_FFFF,
              16'hFFFF);
    drain_results();

    for (int n = 0; n < 950; n++) begin
      steady = (n >= 200 && n < 400);
      send_random_item();
      if (n == 475) drain_results();
    end
    steady = 1'b0;
    drain_results();
    repeat (TABLE_ENTRIES + 16) @(posedge clk_i);

    $display("Covered %0d words: %0d stored, %0d dup, %0d full, %0d translated, %0d missed",
             sb.n_words, sb.n_status[nwrl_pkg::ST_STORED],
             sb.n_status[nwrl_pkg::ST_DUPLICATE], sb.n_status[nwrl_pkg::ST_FULL],
             sb.n_status[nwrl_pkg::ST_TRANSLATED], sb.n_status[nwrl_pkg::ST_NO_MATCH]);
    $display("Hits by rank (exact/exact, exact/any, any/exact, any/any): %0d %0d %0d %0d",
             sb.n_rank[0], sb.n_rank[1], sb.n_rank[2], sb.n_rank[3]);
    if (sb.errors == 0) begin
      $display("nat_wildcard_rule_lookup verification clean");
    end else begin
      $display("nat_wildcard_rule_lookup verification failed");
    end
    $finish;
  end

  initial begin : reply_sink
    int unsigned cyc;
    int unsigned hold_left;
    cyc = 0;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_reply(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32]);
      cyc++;
      // long back-pressure so a result waits in the output register and the next word holds at the end of the row
      if (cyc == 4000) hold_left = 500;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("nat_wildcard_rule_lookup verification failed");
    $finish;
  end

endmodule
